FILE: rtl/srs_pkg.sv
// Shared types, constants and helpers for the streaming substring replacer.
package srs_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BYTE_W          = 8;
    localparam int WIN_DEPTH       = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int LEN_W           = 4;
    localparam int FILL_W          = $clog2(WIN_DEPTH);
    localparam int PTR_W           = $clog2(MAX_RESULTS);
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 5;

    typedef enum logic [1:0] {
        REG_MATCH_PATTERN      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_TEXT   = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_idx_t;

    typedef logic [BYTE_W-1:0] byte_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [MAX_PATTERN*BYTE_W-1:0]     pattern;
        logic [LEN_W-1:0]                  pattern_len;
        logic [MAX_REPLACEMENT*BYTE_W-1:0] replacement;
        logic [LEN_W-1:0]                  replacement_len;
    } cfg_t;

    // Result list produced by one input transaction.
    typedef struct packed {
        byte_t [MAX_RESULTS-1:0] bytes;
        logic  [CNT_W-1:0]       cnt;
        logic                    last_is_end;
    } res_t;

    // Lengths above the cap saturate to the cap.
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len,
                                                  input logic [LEN_W-1:0] cap);
        sat_len = (len > cap) ? cap : len;
    endfunction

endpackage

FILE: rtl/srs_engine.sv
// Window storage, pattern compare and result-list generation for one transaction.
module srs_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_accept,
    input  srs_pkg::byte_t   in_char,
    input  logic             is_end,
    input  srs_pkg::cfg_t    cfg,
    output srs_pkg::res_t    res
);
    import srs_pkg::*;

    byte_t [WIN_DEPTH-1:0] win_reg;
    byte_t [WIN_DEPTH-1:0] win_next;
    logic  [FILL_W-1:0]    fill_reg;
    logic  [FILL_W-1:0]    fill_next;

    logic  [LEN_W-1:0]     plen;
    logic  [LEN_W-1:0]     rlen;
    logic  [LEN_W-1:0]     fill_ext;
    logic                  stale;
    logic                  full;
    logic                  match;
    byte_t [WIN_DEPTH-1:0] ins;

    always_comb begin
        plen     = sat_len(cfg.pattern_len, LEN_W'(MAX_PATTERN));
        rlen     = sat_len(cfg.replacement_len, LEN_W'(MAX_REPLACEMENT));
        fill_ext = LEN_W'(fill_reg);
        stale    = (plen == '0) || (fill_ext >= plen);
        full     = (fill_ext + LEN_W'(1)) == plen;

        ins = win_reg;
        ins[fill_reg] = in_char;

        match = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if ((LEN_W'(i) < plen) && (ins[i] != cfg.pattern[i*BYTE_W +: BYTE_W])) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        res       = '0;
        win_next  = win_reg;
        fill_next = fill_reg;
        priority if (is_end || stale) begin
            // Flush pending bytes, then either the end marker or this byte.
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (LEN_W'(i) < fill_ext) begin
                    res.bytes[i] = win_reg[i];
                end else begin
                    res.bytes[i] = is_end ? '0 : in_char;
                end
            end
            res.cnt         = CNT_W'(fill_ext) + CNT_W'(1);
            res.last_is_end = is_end;
            fill_next       = '0;
        end else if (!full) begin
            win_next  = ins;
            fill_next = fill_reg + FILL_W'(1);
        end else if (match) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                res.bytes[i] = cfg.replacement[i*BYTE_W +: BYTE_W];
            end
            res.cnt   = CNT_W'(rlen);
            fill_next = '0;
        end else begin
            // Emit the oldest byte and slide the window by one.
            res.bytes[0] = ins[0];
            res.cnt      = CNT_W'(1);
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_next[i] = ins[i+1];
            end
            win_next[WIN_DEPTH-1] = ins[WIN_DEPTH-1];
            fill_next = FILL_W'(plen - LEN_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (item_accept) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept) begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: rtl/substring_replace_stream_top.sv
// Top level of the streaming substring replacer: register port, engine and output buffer.
//
// This block takes a text stream one byte per transaction, with a final transaction whose
// s_is_end flag marks the end of the string, and replaces every leftmost, non-overlapping
// occurrence of the configured pattern (up to 8 bytes) with the configured replacement
// (up to 8 bytes, possibly empty). A byte that arrives while the window is filling
// produces no output; a completed window produces either the replacement or its oldest
// byte; the end transaction flushes the window and ends with one result that has
// m_out_end set and m_out_char zero. The whole decision for an input transaction is
// made in the cycle it is accepted, and its results (up to 8) are loaded into an
// output buffer that drains one result per cycle while m_ready is high, the first one
// visible the cycle after acceptance. A new input is accepted whenever that buffer is
// empty or is handing over its last result, so the block takes one byte per cycle as
// long as each byte yields at most one result and m_ready stays high; a transaction
// that yields results holds off the next input until the buffer hands over its last
// one, and one that yields none leaves the input free. Lengths above 8 saturate to 8 and
// an empty pattern passes text through. Registers sit at byte addresses 0, 8, 16 and 24
// (pattern, pattern length, replacement, replacement length), are 64 bits wide, reset to
// zero, and should only be written while no transaction is in flight.
module substring_replace_stream_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [srs_pkg::BYTE_W-1:0]          s_in_char,
    input  logic                                s_is_end,
    // Result stream
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [srs_pkg::BYTE_W-1:0]          m_out_char,
    output logic                                m_out_end,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [srs_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [srs_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import srs_pkg::*;

    cfg_t     cfg_reg;
    cfg_idx_t cfg_idx;
    logic     cfg_write;

    res_t     res;
    logic     item_accept;

    byte_t [MAX_RESULTS-1:0] obuf_data_reg;
    logic  [CNT_W-1:0]       obuf_cnt_reg;
    logic  [CNT_W-1:0]       obuf_cnt_next;
    logic  [PTR_W-1:0]       obuf_ptr_reg;
    logic  [PTR_W-1:0]       obuf_ptr_next;
    logic                    obuf_end_reg;
    logic                    obuf_pop;

    // Register port: zero wait states, the word index comes from the upper address bits.
    assign pready    = 1'b1;
    assign cfg_idx   = cfg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_MATCH_PATTERN:      cfg_reg.pattern         <= pwdata;
                REG_PATTERN_LENGTH:     cfg_reg.pattern_len     <= pwdata[LEN_W-1:0];
                REG_REPLACEMENT_TEXT:   cfg_reg.replacement     <= pwdata;
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_len <= pwdata[LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MATCH_PATTERN:      prdata = cfg_reg.pattern;
            REG_PATTERN_LENGTH:     prdata = CFG_DATA_W'(cfg_reg.pattern_len);
            REG_REPLACEMENT_TEXT:   prdata = cfg_reg.replacement;
            REG_REPLACEMENT_LENGTH: prdata = CFG_DATA_W'(cfg_reg.replacement_len);
        endcase
    end

    // The input is taken when the buffer will be free at the next edge.
    assign m_valid     = (obuf_cnt_reg != '0);
    assign obuf_pop    = m_valid && m_ready;
    assign s_ready     = (obuf_cnt_reg == '0) || ((obuf_cnt_reg == CNT_W'(1)) && m_ready);
    assign item_accept = s_valid && s_ready;

    srs_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .in_char     (s_in_char),
        .is_end      (s_is_end),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // Output buffer: a new list replaces the drained one; otherwise step through it.
    always_comb begin
        obuf_cnt_next = obuf_cnt_reg;
        obuf_ptr_next = obuf_ptr_reg;
        priority if (item_accept) begin
            obuf_cnt_next = res.cnt;
            obuf_ptr_next = '0;
        end else if (obuf_pop) begin
            obuf_cnt_next = obuf_cnt_reg - CNT_W'(1);
            obuf_ptr_next = obuf_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obuf_cnt_reg <= '0;
            obuf_ptr_reg <= '0;
        end else begin
            obuf_cnt_reg <= obuf_cnt_next;
            obuf_ptr_reg <= obuf_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept) begin
            obuf_data_reg <= res.bytes;
            obuf_end_reg  <= res.last_is_end;
        end
    end

    // The end marker, when present, is always the last result of the list.
    assign m_out_char = obuf_data_reg[obuf_ptr_reg];
    assign m_out_end  = obuf_end_reg && (obuf_cnt_reg == CNT_W'(1));

endmodule
